### sv/fpcrc_pkg.sv
// shared types, constants and the byte-wide crc step for the framed packet parser
// no dependencies; used by every other file of the block except fpcrc_in_stage

package fpcrc_pkg;

   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [7:0]  HEADER_INIT = 8'h55;

   // one-hot frame phase
   typedef enum logic [5:0] {
      PH_HUNT  = 6'b000001,
      PH_ID    = 6'b000010,
      PH_LEN   = 6'b000100,
      PH_DATA  = 6'b001000,
      PH_CK_LO = 6'b010000,
      PH_CK_HI = 6'b100000
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD   = 1'b0,
      KIND_FRAME_END = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  frame_id;
      logic [7:0]  payload_index;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_length;
      logic        crc_good;
      logic [31:0] good_count;
      logic [31:0] bad_count;
   } result_type;

   // msb-first crc-16 over one byte, eight shift steps on a 16-bit value
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### sv/fpcrc_if.sv
// channel interfaces of the framed packet parser: request, response and csr write
// depends on fpcrc_pkg for the result kind type

interface fpcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpcrc_rsp_if;
   logic                valid;
   logic                ready;
   fpcrc_pkg::kind_type kind;
   logic [7:0]          frame_id;
   logic [7:0]          payload_index;
   logic [7:0]          payload_byte;
   logic [7:0]          frame_length;
   logic                crc_good;
   logic [31:0]         good_count;
   logic [31:0]         bad_count;
   modport source (output valid, output kind, output frame_id, output payload_index,
                   output payload_byte, output frame_length, output crc_good,
                   output good_count, output bad_count, input ready);
   modport sink   (input valid, input kind, input frame_id, input payload_index,
                   input payload_byte, input frame_length, input crc_good,
                   input good_count, input bad_count, output ready);
endinterface

interface fpcrc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   modport source (output valid, output header_byte, input ready);
   modport sink   (input valid, input header_byte, output ready);
endinterface

### sv/fpcrc_in_stage.sv
// input register of the framed packet parser: holds one received byte beat
// no package dependency

module fpcrc_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // room when empty or when the held beat moves on this cycle
   assign in_ready   = !valid_ff || advance;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
      end
   end

endmodule

### sv/fpcrc_parser.sv
// frame state machine, running crc and frame counters
// depends on fpcrc_pkg for the phase type, result type and crc_feed

module fpcrc_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            header_byte,
   output logic                  res_valid,
   output fpcrc_pkg::result_type res
);

   fpcrc_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  ck_lo_ff, ck_lo_in;
   logic [31:0] ok_ff, ok_in;
   logic [31:0] bad_ff, bad_in;
   logic [15:0] crc_next;
   logic [7:0]  pos_inc;
   logic        good;

   assign crc_next = fpcrc_pkg::crc_feed(crc_ff, rx_byte);
   assign pos_inc  = pos_ff + 8'd1;
   assign good     = ({rx_byte, ck_lo_ff} == crc_ff);

   always_comb begin
      phase_in  = phase_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      ck_lo_in  = ck_lo_ff;
      ok_in     = ok_ff;
      bad_in    = bad_ff;
      res_valid = 1'b0;
      res.kind          = fpcrc_pkg::KIND_PAYLOAD;
      res.frame_id      = id_ff;
      res.payload_index = pos_ff;
      res.payload_byte  = rx_byte;
      res.frame_length  = len_ff;
      res.crc_good      = 1'b0;
      res.good_count    = ok_ff;
      res.bad_count     = bad_ff;
      if (advance) begin
         unique case (phase_ff)
            fpcrc_pkg::PH_HUNT: begin
               if (rx_byte == header_byte) begin
                  crc_in   = fpcrc_pkg::crc_feed(fpcrc_pkg::CRC_INIT, rx_byte);
                  phase_in = fpcrc_pkg::PH_ID;
               end
            end
            fpcrc_pkg::PH_ID: begin
               id_in    = rx_byte;
               crc_in   = crc_next;
               phase_in = fpcrc_pkg::PH_LEN;
            end
            fpcrc_pkg::PH_LEN: begin
               len_in   = rx_byte;
               pos_in   = 8'd0;
               crc_in   = crc_next;
               phase_in = (rx_byte == 8'd0) ? fpcrc_pkg::PH_CK_LO : fpcrc_pkg::PH_DATA;
            end
            fpcrc_pkg::PH_DATA: begin
               crc_in    = crc_next;
               res_valid = 1'b1;
               if (pos_inc >= len_ff) begin
                  pos_in   = 8'd0;
                  phase_in = fpcrc_pkg::PH_CK_LO;
               end else begin
                  pos_in = pos_inc;
               end
            end
            fpcrc_pkg::PH_CK_LO: begin
               ck_lo_in = rx_byte;
               phase_in = fpcrc_pkg::PH_CK_HI;
            end
            fpcrc_pkg::PH_CK_HI: begin
               if (good) begin
                  ok_in = ok_ff + 32'd1;
               end else begin
                  bad_in = bad_ff + 32'd1;
               end
               phase_in          = fpcrc_pkg::PH_HUNT;
               res_valid         = 1'b1;
               res.kind          = fpcrc_pkg::KIND_FRAME_END;
               res.payload_index = 8'd0;
               res.payload_byte  = 8'd0;
               res.crc_good      = good;
               res.good_count    = ok_in;
               res.bad_count     = bad_in;
            end
            default: begin
               phase_in = fpcrc_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fpcrc_pkg::PH_HUNT;
         id_ff    <= 8'd0;
         len_ff   <= 8'd0;
         pos_ff   <= 8'd0;
         crc_ff   <= fpcrc_pkg::CRC_INIT;
         ck_lo_ff <= 8'd0;
         ok_ff    <= 32'd0;
         bad_ff   <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         ck_lo_ff <= ck_lo_in;
         ok_ff    <= ok_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

### sv/fpcrc_out_stage.sv
// result register of the framed packet parser, decoupling the response channel
// depends on fpcrc_pkg for the result type

module fpcrc_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  res_valid,
   input  fpcrc_pkg::result_type res,
   output logic                  out_free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output fpcrc_pkg::result_type out_res
);

   logic                  valid_ff, valid_in;
   fpcrc_pkg::result_type res_ff;

   assign out_free  = !valid_ff || out_ready;
   assign valid_in  = load ? res_valid : (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         res_ff <= res;
      end
   end

endmodule

### sv/framed_packet_parser_crc16_unit.sv
// Framed packet parser with on-the-fly CRC-16 (poly 0x1021, init 0xFFFF, msb first).
// One received byte beat is taken per clock cycle, sustained, whatever the frame phase,
// as long as the response side keeps taking results. Each beat is held in the input
// register, where the parser's byte-wide crc and frame state update works on it, and
// its result is loaded into the result register. Payload bytes give one result each,
// the second checksum byte gives a frame-end result; other bytes give none. The header
// register takes effect from the next hunt; the user must write it only while no frame
// beat is in flight; the block does not enforce it. No clearing pass runs after reset.
// depends on fpcrc_pkg, fpcrc_if, fpcrc_in_stage, fpcrc_parser and fpcrc_out_stage

module framed_packet_parser_crc16_unit (
   input  logic clock,
   input  logic reset,
   fpcrc_req_if.sink   req,
   fpcrc_rsp_if.source rsp,
   fpcrc_csr_if.sink   csr
);

   logic                  held_valid;
   logic [7:0]            held_byte;
   logic                  out_free;
   logic                  advance;
   logic                  res_valid;
   fpcrc_pkg::result_type res;
   fpcrc_pkg::result_type out_res;
   logic [7:0]            header_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= fpcrc_pkg::HEADER_INIT;
      end else if (csr.valid) begin
         header_ff <= csr.header_byte;
      end
   end

   // the held beat moves into the parser when the result register can take its result
   assign advance = held_valid && out_free;

   fpcrc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .in_byte    (req.rx_byte),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   fpcrc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rx_byte     (held_byte),
      .header_byte (header_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   fpcrc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_res   (out_res)
   );

   assign rsp.kind          = out_res.kind;
   assign rsp.frame_id      = out_res.frame_id;
   assign rsp.payload_index = out_res.payload_index;
   assign rsp.payload_byte  = out_res.payload_byte;
   assign rsp.frame_length  = out_res.frame_length;
   assign rsp.crc_good      = out_res.crc_good;
   assign rsp.good_count    = out_res.good_count;
   assign rsp.bad_count     = out_res.bad_count;

endmodule

### sv/fpcrc_checker.sv
// port-level checks on the framed packet parser response channel, bound to the top level
// depends on fpcrc_pkg for the result kind codes

module fpcrc_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input fpcrc_pkg::kind_type rsp_kind,
   input logic [7:0]          rsp_payload_index,
   input logic [7:0]          rsp_payload_byte,
   input logic                rsp_crc_good,
   input logic [31:0]         rsp_good_count,
   input logic [31:0]         rsp_bad_count
);

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_payload_index) && $stable(rsp_payload_byte) &&
      $stable(rsp_good_count) && $stable(rsp_bad_count))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_payload_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fpcrc_pkg::KIND_PAYLOAD |-> !rsp_crc_good)
      else $error("payload beat carries a crc verdict");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == fpcrc_pkg::KIND_FRAME_END |->
      rsp_payload_index == 8'd0 && rsp_payload_byte == 8'd0)
      else $error("frame end beat carries payload fields");

endmodule

bind framed_packet_parser_crc16_unit fpcrc_checker u_fpcrc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_kind          (rsp.kind),
   .rsp_payload_index (rsp.payload_index),
   .rsp_payload_byte  (rsp.payload_byte),
   .rsp_crc_good      (rsp.crc_good),
   .rsp_good_count    (rsp.good_count),
   .rsp_bad_count     (rsp.bad_count)
);
